[rtl/fim_pkg.sv]
// ============================================================================
// fim_pkg
// Shared constants of the free interval manager.
// ============================================================================
package fim_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int COORD_BITS    = 31;

    localparam logic [2:0] REQ_RELEASE  = 3'd0;
    localparam logic [2:0] REQ_RESERVE  = 3'd1;
    localparam logic [2:0] REQ_FIND_AT  = 3'd2;
    localparam logic [2:0] REQ_FIND_FIT = 3'd3;
    localparam logic [2:0] REQ_LARGEST  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

[rtl/fim_ram.sv]
// ============================================================================
// fim_ram
// Generic single-port RAM with registered read.
// ============================================================================
module fim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/free_interval_manager.sv]
// ============================================================================
// free_interval_manager
// Sorted table of disjoint free intervals with release, reserve and lookups.
// ============================================================================
// Per request: a scan reads and checks the entries it visits, a tail move reads and
// writes each entry moved (release and reserve only), then a totals pass reads and
// checks every entry before the response.
// One request at a time; s_tready is high only while idle.
// Reset clears count, span, cached largest and sets the fit policy to 1.
module free_interval_manager #(
    parameter int MAX_SLOTS = fim_pkg::MAX_SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // req_type[2:0], range_start[33:3], range_end[64:34], point[95:65],
    // length[126:96], zero pad
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // status[1:0], found_start[32:2], found_end[63:33], free_total[94:64],
    // free_count[101:95], largest_length[132:102], largest_start[164:133],
    // earliest_start[196:165], latest_end[228:197], occupied_total[259:229],
    // zero pad
    output logic [263:0]  m_tdata
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int CB = fim_pkg::COORD_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SRD   = 5'd1;
    localparam logic [4:0] S_SCHK  = 5'd2;
    localparam logic [4:0] S_DEC   = 5'd3;
    localparam logic [4:0] S_MVRD  = 5'd4;
    localparam logic [4:0] S_MVWR  = 5'd5;
    localparam logic [4:0] S_PWR   = 5'd6;
    localparam logic [4:0] S_TRD   = 5'd7;
    localparam logic [4:0] S_TCHK  = 5'd8;
    localparam logic [4:0] S_FIN   = 5'd9;
    localparam logic [4:0] S_OUT   = 5'd10;

    logic [4:0]    state_reg, state_next;
    logic          policy_reg;
    logic [CW-1:0] count_reg;
    logic [CB-1:0] span_reg, cached_reg;

    logic [2:0]    req_reg;
    logic [CB-1:0] rs_reg, re_reg, pt_reg, len_reg;

    // scan cursor and lo/hi bounds
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic          lodone_reg;
    logic [CB-1:0] los_reg, hie_reg;
    logic [CB-1:0] prev_e_reg;
    logic          prev_v_reg;

    // pieces and shift
    logic [1:0]    np_reg, pi_reg;
    logic [CB-1:0] p0s_reg, p0e_reg, p1s_reg, p1e_reg;
    logic [CW-1:0] newcnt_reg;
    logic [CW-1:0] src_reg, dst_reg;
    logic          up_reg;

    // find result
    logic [1:0]    st_reg;
    logic [CB-1:0] fs_reg, fe_reg;
    logic          done_reg;
    logic [CB-1:0] best_reg;

    // totals
    logic [CB-1:0] tot_reg, lmax_reg, lst_reg, est_reg, lend_reg;

    logic          we;
    logic [AW-1:0] addr;
    logic [CB-1:0] wd_s, wd_e, rd_s, rd_e;

    fim_ram #(.WIDTH(CB), .DEPTH(MAX_SLOTS)) u_starts (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wd_s), .rdata(rd_s)
    );
    fim_ram #(.WIDTH(CB), .DEPTH(MAX_SLOTS)) u_ends (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wd_e), .rdata(rd_e)
    );

    logic [CB-1:0] avail;
    assign avail = rd_e - rd_s;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);

    logic [CB-1:0] occ;
    assign occ = (span_reg > tot_reg) ? span_reg - tot_reg : '0;

    logic [31:0] lst32, est32, lend32;
    assign lst32  = (count_reg == '0) ? 32'hFFFF_FFFF : 32'(lst_reg);
    assign est32  = (count_reg == '0) ? 32'hFFFF_FFFF : 32'(est_reg);
    assign lend32 = (count_reg == '0) ? 32'hFFFF_FFFF : 32'(lend_reg);

    assign m_tdata = {4'd0, 31'(occ), lend32, est32, lst32, 31'(lmax_reg),
                      7'(count_reg), 31'(tot_reg), 31'(fe_reg), 31'(fs_reg), st_reg};

    logic is_rel, is_rng;
    assign is_rel = (req_reg == fim_pkg::REQ_RELEASE);
    assign is_rng = is_rel || (req_reg == fim_pkg::REQ_RESERVE);

    // scan step predicates
    logic lo_adv, hi_adv;
    assign lo_adv = is_rel ? (rd_e < rs_reg) : (rd_e <= rs_reg);
    assign hi_adv = is_rel ? (rd_s <= re_reg) : (rd_s < re_reg);

    logic fit_ok, prev_hit;
    assign fit_ok   = (cached_reg >= len_reg) && (avail >= len_reg);
    assign prev_hit = prev_v_reg && (prev_e_reg >= pt_reg) && (prev_e_reg - pt_reg >= len_reg);

    logic scan_stop;
    always_comb begin
        case (req_reg) inside
            fim_pkg::REQ_RELEASE, fim_pkg::REQ_RESERVE:
                scan_stop = !((!lodone_reg && lo_adv) || hi_adv);
            fim_pkg::REQ_FIND_AT:  scan_stop = (rd_s >= pt_reg);
            fim_pkg::REQ_FIND_FIT: scan_stop = fit_ok && policy_reg;
            fim_pkg::REQ_LARGEST:  scan_stop = (avail == cached_reg) && (cached_reg != '0);
            default:               scan_stop = 1'b1;
        endcase
    end

    logic [CW-1:0] del;
    assign del = hi_reg - lo_reg;

    logic          res_a, res_b;
    logic [CW-1:0] res_np, pieces;
    logic          rel_full, res_full, full_hit, do_shift;
    assign res_a    = los_reg < rs_reg;
    assign res_b    = hie_reg > re_reg;
    assign res_np   = CW'(res_a) + CW'(res_b);
    assign pieces   = is_rel ? CW'(1) : res_np;
    assign rel_full = (hi_reg == lo_reg) && (count_reg >= CW'(MAX_SLOTS));
    assign res_full = (hi_reg > lo_reg) && (count_reg - del + res_np > CW'(MAX_SLOTS));
    assign full_hit = is_rel ? rel_full : res_full;
    assign do_shift = is_rng && (rs_reg < re_reg) && !full_hit && (is_rel || hi_reg > lo_reg);

    logic mv_stop;
    assign mv_stop = up_reg ? (src_reg < hi_reg || src_reg >= count_reg)
                            : (src_reg >= count_reg);

    always_comb begin
        state_next = state_reg;
        we   = 1'b0;
        addr = AW'(idx_reg);
        wd_s = p0s_reg;
        wd_e = p0e_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SRD;
                end
            end
            S_SRD: begin
                if (idx_reg < count_reg) begin
                    state_next = S_SCHK;
                end else begin
                    state_next = S_DEC;
                end
            end
            S_SCHK: state_next = S_SRD;
            S_DEC: begin
                state_next = do_shift ? S_MVRD : S_FIN;
            end
            S_MVRD: begin
                addr = AW'(src_reg);
                state_next = mv_stop ? S_PWR : S_MVWR;
            end
            S_MVWR: begin
                addr = AW'(dst_reg);
                wd_s = rd_s;
                wd_e = rd_e;
                we   = 1'b1;
                state_next = S_MVRD;
            end
            S_PWR: begin
                addr = AW'(dst_reg);
                we   = (pi_reg < np_reg);
                wd_s = (pi_reg == 2'd0) ? p0s_reg : p1s_reg;
                wd_e = (pi_reg == 2'd0) ? p0e_reg : p1e_reg;
                state_next = (pi_reg < np_reg) ? S_PWR : S_FIN;
            end
            S_TRD: begin
                if (idx_reg < count_reg) begin
                    state_next = S_TCHK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_TCHK: state_next = S_TRD;
            S_FIN: state_next = S_TRD;
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            policy_reg <= 1'b1;
            count_reg  <= '0;
            span_reg   <= '0;
            cached_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg    <= s_tdata[2:0];
                        rs_reg     <= CB'(s_tdata[33:3]);
                        re_reg     <= CB'(s_tdata[64:34]);
                        pt_reg     <= CB'(s_tdata[95:65]);
                        len_reg    <= CB'(s_tdata[126:96]);
                        idx_reg    <= '0;
                        lo_reg     <= '0;
                        hi_reg     <= '0;
                        lodone_reg <= 1'b0;
                        prev_v_reg <= 1'b0;
                        done_reg   <= 1'b0;
                        st_reg     <= fim_pkg::ST_NONE;
                        fs_reg     <= '0;
                        fe_reg     <= '0;
                        np_reg     <= '0;
                    end
                end
                S_SRD: ;
                S_SCHK: begin
                    idx_reg <= scan_stop ? count_reg : idx_reg + 1'b1;
                    case (req_reg) inside
                        fim_pkg::REQ_RELEASE, fim_pkg::REQ_RESERVE: begin
                            if (!lodone_reg && lo_adv) begin
                                lo_reg <= idx_reg + 1'b1;
                                hi_reg <= idx_reg + 1'b1;
                            end else if (hi_adv) begin
                                if (!lodone_reg || hi_reg == lo_reg) begin
                                    los_reg <= rd_s;
                                end
                                lodone_reg <= 1'b1;
                                hi_reg     <= idx_reg + 1'b1;
                                hie_reg    <= rd_e;
                            end else begin
                                lodone_reg <= 1'b1;
                            end
                        end
                        fim_pkg::REQ_FIND_AT: begin
                            if (rd_s < pt_reg) begin
                                prev_e_reg <= rd_e;
                                prev_v_reg <= 1'b1;
                            end else begin
                                done_reg <= 1'b1;
                                if (rd_s == pt_reg && rd_e - pt_reg >= len_reg) begin
                                    st_reg <= fim_pkg::ST_OK;
                                    fs_reg <= pt_reg;
                                    fe_reg <= pt_reg + len_reg;
                                end else if (rd_s > pt_reg && avail >= len_reg) begin
                                    st_reg <= fim_pkg::ST_OK;
                                    fs_reg <= rd_s;
                                    fe_reg <= rd_s + len_reg;
                                end else if (prev_hit) begin
                                    st_reg <= fim_pkg::ST_OK;
                                    fs_reg <= pt_reg;
                                    fe_reg <= pt_reg + len_reg;
                                end
                            end
                        end
                        fim_pkg::REQ_FIND_FIT: begin
                            if (fit_ok) begin
                                if (policy_reg) begin
                                    if (!done_reg) begin
                                        st_reg <= fim_pkg::ST_OK;
                                        fs_reg <= rd_s;
                                        fe_reg <= rd_s + len_reg;
                                        done_reg <= 1'b1;
                                    end
                                end else if (!done_reg || avail < best_reg) begin
                                    st_reg <= fim_pkg::ST_OK;
                                    best_reg <= avail;
                                    fs_reg <= rd_s;
                                    fe_reg <= rd_s + len_reg;
                                    done_reg <= 1'b1;
                                end
                            end
                        end
                        fim_pkg::REQ_LARGEST: begin
                            if (!done_reg && avail == cached_reg && cached_reg != '0) begin
                                st_reg <= fim_pkg::ST_OK;
                                fs_reg <= rd_s;
                                fe_reg <= rd_e;
                                done_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DEC: begin
                    if (req_reg == fim_pkg::REQ_FIND_AT && !done_reg && prev_hit) begin
                        st_reg <= fim_pkg::ST_OK;
                        fs_reg <= pt_reg;
                        fe_reg <= pt_reg + len_reg;
                    end
                    if (is_rng) begin
                        if (rs_reg >= re_reg) begin
                            st_reg <= fim_pkg::ST_EMPTY;
                        end else if (full_hit) begin
                            st_reg <= fim_pkg::ST_FULL;
                        end else begin
                            st_reg <= fim_pkg::ST_OK;
                            if (span_reg == '0) span_reg <= re_reg - rs_reg;
                            np_reg <= pieces[1:0];
                            if (is_rel) begin
                                p0s_reg <= (hi_reg > lo_reg && los_reg < rs_reg) ? los_reg : rs_reg;
                                p0e_reg <= (hi_reg > lo_reg && hie_reg > re_reg) ? hie_reg : re_reg;
                            end else begin
                                p0s_reg <= res_a ? los_reg : re_reg;
                                p0e_reg <= res_a ? rs_reg : hie_reg;
                            end
                            p1s_reg    <= re_reg;
                            p1e_reg    <= hie_reg;
                            newcnt_reg <= count_reg - del + pieces;
                            up_reg     <= (pieces > del);
                            src_reg    <= (pieces > del) ? count_reg - 1'b1 : hi_reg;
                            dst_reg    <= (pieces > del) ? count_reg : lo_reg + pieces;
                        end
                    end
                end
                S_MVRD: begin
                    if (mv_stop) begin
                        dst_reg <= lo_reg;
                        pi_reg  <= '0;
                    end
                end
                S_MVWR: begin
                    if (up_reg) begin
                        src_reg <= src_reg - 1'b1;
                        dst_reg <= dst_reg - 1'b1;
                    end else begin
                        src_reg <= src_reg + 1'b1;
                        dst_reg <= dst_reg + 1'b1;
                    end
                end
                S_PWR: begin
                    if (pi_reg < np_reg) begin
                        pi_reg  <= pi_reg + 1'b1;
                        dst_reg <= dst_reg + 1'b1;
                    end else begin
                        count_reg <= newcnt_reg;
                    end
                end
                S_FIN: begin
                    idx_reg  <= '0;
                    tot_reg  <= '0;
                    lmax_reg <= '0;
                    lst_reg  <= '0;
                end
                S_TRD: begin
                    if (idx_reg >= count_reg) cached_reg <= lmax_reg;
                end
                S_TCHK: begin
                    idx_reg <= idx_reg + 1'b1;
                    tot_reg <= tot_reg + avail;
                    if (avail > lmax_reg) begin
                        lmax_reg <= avail;
                        lst_reg  <= rd_s;
                    end
                    if (idx_reg == '0) est_reg <= rd_s;
                    lend_reg <= rd_e;
                end
                default: ;
            endcase
        end
    end

endmodule

[tb/tb_free_interval_manager.sv]
// ============================================================================
// tb_free_interval_manager
// Self-checking bench for the free interval manager: a directed request table
// followed by random release/reserve/lookup traffic, each response compared
// field by field against an in-bench model of the interval table.
// ============================================================================
module tb_free_interval_manager;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = fim_pkg::MAX_SLOTS_DEF;

    typedef struct packed {
        logic [30:0] length;
        logic [30:0] point;
        logic [30:0] range_end;
        logic [30:0] range_start;
        logic [2:0]  req_type;
    } request_t;

    typedef struct packed {
        logic [30:0] occupied_total;
        logic [31:0] latest_end;
        logic [31:0] earliest_start;
        logic [31:0] largest_start;
        logic [30:0] largest_length;
        logic [6:0]  free_count;
        logic [30:0] free_total;
        logic [30:0] found_end;
        logic [30:0] found_start;
        logic [1:0]  status;
    } response_t;

    typedef struct {
        request_t  req;
        bit        has_status;
        logic [1:0] status;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic cfg_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [263:0] m_tdata;

    free_interval_manager dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb_free_interval_manager NOT OK");
        $finish;
    end

    // interval table model
    logic [30:0] iv_start [SLOTS];
    logic [30:0] iv_end [SLOTS];
    int iv_count;
    logic [30:0] span_seen;
    logic [30:0] largest_cache;
    bit lowest_first;

    response_t pending [$];
    int errors;
    int n_resp;
    int n_found;
    int n_full;
    bit stall_hold;

    function automatic void splice_in(int lo, int hi, logic [30:0] ps[2], logic [30:0] pe[2],
                                      int np);
        logic [30:0] ts [SLOTS];
        logic [30:0] te [SLOTS];
        int n;
        n = 0;
        for (int i = 0; i < lo; i++) begin ts[n] = iv_start[i]; te[n] = iv_end[i]; n++; end
        for (int i = 0; i < np; i++) begin ts[n] = ps[i]; te[n] = pe[i]; n++; end
        for (int i = hi; i < iv_count; i++) begin
            ts[n] = iv_start[i]; te[n] = iv_end[i]; n++;
        end
        for (int i = 0; i < n; i++) begin iv_start[i] = ts[i]; iv_end[i] = te[i]; end
        iv_count = n;
    endfunction

    function automatic logic [1:0] release_range(logic [30:0] s, logic [30:0] e);
        int lo;
        int hi;
        logic [30:0] ps[2];
        logic [30:0] pe[2];
        lo = 0;
        while (lo < iv_count && iv_end[lo] < s) lo++;
        hi = lo;
        while (hi < iv_count && iv_start[hi] <= e) hi++;
        if (hi == lo && iv_count >= SLOTS) return fim_pkg::ST_FULL;
        ps[0] = s;
        pe[0] = e;
        if (hi > lo) begin
            if (iv_start[lo] < s) ps[0] = iv_start[lo];
            if (iv_end[hi-1] > e) pe[0] = iv_end[hi-1];
        end
        if (span_seen == 0) span_seen = e - s;
        splice_in(lo, hi, ps, pe, 1);
        return fim_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] reserve_range(logic [30:0] s, logic [30:0] e);
        int lo;
        int hi;
        int np;
        logic [30:0] ps[2];
        logic [30:0] pe[2];
        lo = 0;
        np = 0;
        while (lo < iv_count && iv_end[lo] <= s) lo++;
        hi = lo;
        while (hi < iv_count && iv_start[hi] < e) hi++;
        if (hi > lo) begin
            if (iv_start[lo] < s) begin ps[np] = iv_start[lo]; pe[np] = s; np++; end
            if (iv_end[hi-1] > e) begin ps[np] = e; pe[np] = iv_end[hi-1]; np++; end
            if (iv_count - (hi - lo) + np > SLOTS) return fim_pkg::ST_FULL;
        end
        if (span_seen == 0) span_seen = e - s;
        if (hi > lo) splice_in(lo, hi, ps, pe, np);
        return fim_pkg::ST_OK;
    endfunction

    function automatic response_t predict_response(request_t r);
        response_t o;
        logic [30:0] p;
        logic [30:0] len;
        logic [30:0] total;
        logic [30:0] lmax;
        logic [30:0] sz;
        logic [30:0] best_sz;
        int i;
        int best;
        o = '0;
        o.status = fim_pkg::ST_NONE;
        p = r.point;
        len = r.length;
        case (r.req_type) inside
            fim_pkg::REQ_RELEASE, fim_pkg::REQ_RESERVE: begin
                if (r.range_start >= r.range_end) o.status = fim_pkg::ST_EMPTY;
                else if (r.req_type == fim_pkg::REQ_RELEASE)
                    o.status = release_range(r.range_start, r.range_end);
                else o.status = reserve_range(r.range_start, r.range_end);
            end
            fim_pkg::REQ_FIND_AT: begin
                i = 0;
                while (i < iv_count && iv_start[i] < p) i++;
                if (i < iv_count && iv_start[i] == p && iv_end[i] - p >= len) begin
                    o.status = fim_pkg::ST_OK; o.found_start = p; o.found_end = p + len;
                end else if (i < iv_count && iv_start[i] > p &&
                             iv_end[i] - iv_start[i] >= len) begin
                    o.status = fim_pkg::ST_OK; o.found_start = iv_start[i];
                    o.found_end = iv_start[i] + len;
                end else if (i > 0 && iv_end[i-1] >= p && iv_end[i-1] - p >= len) begin
                    o.status = fim_pkg::ST_OK; o.found_start = p; o.found_end = p + len;
                end
            end
            fim_pkg::REQ_FIND_FIT: begin
                best = -1;
                best_sz = '0;
                if (largest_cache >= len) begin
                    for (i = 0; i < iv_count; i++) begin
                        sz = iv_end[i] - iv_start[i];
                        if (sz < len) continue;
                        if (lowest_first) begin best = i; break; end
                        if (best < 0 || sz < best_sz) begin best = i; best_sz = sz; end
                    end
                end
                if (best >= 0) begin
                    o.status = fim_pkg::ST_OK; o.found_start = iv_start[best];
                    o.found_end = iv_start[best] + len;
                end
            end
            fim_pkg::REQ_LARGEST: begin
                for (i = 0; i < iv_count; i++) begin
                    if (largest_cache != 0 && iv_end[i] - iv_start[i] == largest_cache) begin
                        o.status = fim_pkg::ST_OK; o.found_start = iv_start[i];
                        o.found_end = iv_end[i];
                        break;
                    end
                end
            end
            default: o.status = fim_pkg::ST_NONE;
        endcase
        total = '0;
        lmax = '0;
        o.largest_start = '1;
        o.earliest_start = '1;
        o.latest_end = '1;
        for (i = 0; i < iv_count; i++) begin
            sz = iv_end[i] - iv_start[i];
            total += sz;
            if (sz > lmax) begin lmax = sz; o.largest_start = {1'b0, iv_start[i]}; end
        end
        if (iv_count > 0) begin
            o.earliest_start = {1'b0, iv_start[0]};
            o.latest_end = {1'b0, iv_end[iv_count-1]};
        end
        largest_cache = lmax;
        o.free_total = total;
        o.free_count = 7'(iv_count);
        o.largest_length = lmax;
        o.occupied_total = span_seen > total ? span_seen - total : '0;
        return o;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 3);
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_request(request_t r, bit has_status, logic [1:0] st);
        response_t exp;
        if (stall_hold) @(posedge aclk);
        else idle_gap();
        exp = predict_response(r);
        if (has_status && exp.status !== st) begin
            $display("%0t table row status: expected %0d, model %0d", $time, st, exp.status);
            errors++;
        end
        pending = {pending, exp};
        s_tvalid <= 1;
        s_tdata <= {1'b0, r};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 0;
    endtask

    task automatic write_policy(bit v);
        while (pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        lowest_first = v;
    endtask

    function automatic logic [30:0] rnd_coord(int mode);
        case (mode)
            0: return 31'($urandom_range(0, 4000));
            1: return 31'(32'h7fffffff - $urandom_range(0, 100));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic request_t rnd_request(int deep);
        request_t r;
        int m;
        int t;
        logic [30:0] a;
        logic [30:0] b;
        m = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
        t = $urandom_range(0, 9);
        if (t > 4) t = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7)
                       : $urandom_range(0, 1);
        r.req_type = 3'(t);
        a = rnd_coord(m);
        b = ($urandom_range(0, 15) == 0) ? rnd_coord(m)
            : 31'(a + $urandom_range(deep ? 1 : 0, deep ? 60 : 400));
        r.range_start = a;
        r.range_end = b;
        r.point = rnd_coord(m);
        r.length = ($urandom_range(0, 9) == 0) ? rnd_coord(2) : 31'($urandom_range(0, 300));
        return r;
    endfunction

    // response side: random stalls, check against oldest expectation
    initial begin
        response_t got;
        response_t exp;
        int n;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[259:0];
                if (pending.size() == 0) begin
                    $display("%0t unexpected response %h", $time, got);
                    errors++;
                end else begin
                    exp = pending.pop_front();
                    n_resp++;
                    if (got.status == fim_pkg::ST_OK) n_found++;
                    if (got.status == fim_pkg::ST_FULL) n_full++;
                    if (got !== exp) begin
                        errors++;
                        $display("%0t mismatch status exp %0d got %0d", $time,
                                 exp.status, got.status);
                        $display("  found exp %0d..%0d got %0d..%0d", exp.found_start,
                                 exp.found_end, got.found_start, got.found_end);
                        $display("  total/count exp %0d/%0d got %0d/%0d", exp.free_total,
                                 exp.free_count, got.free_total, got.free_count);
                        $display("  largest exp %0d@%0d got %0d@%0d", exp.largest_length,
                                 $signed(exp.largest_start), got.largest_length,
                                 $signed(got.largest_start));
                        $display("  bounds exp %0d/%0d got %0d/%0d occ exp %0d got %0d",
                                 $signed(exp.earliest_start), $signed(exp.latest_end),
                                 $signed(got.earliest_start), $signed(got.latest_end),
                                 exp.occupied_total, got.occupied_total);
                    end
                end
            end
            if (!aresetn) m_tready <= 1'b0;
            else if (stall_hold) m_tready <= 1'b1;
            else begin
                n = $urandom_range(0, 19);
                m_tready <= (n == 0) ? 1'b0 : ((n < 4) ? 1'($urandom_range(0, 1)) : 1'b1);
            end
        end
    end

    row_t table_rows [$];

    function automatic void add_row(logic [2:0] t, logic [30:0] s, logic [30:0] e,
                                    logic [30:0] p, logic [30:0] l, bit hs, logic [1:0] st);
        row_t w;
        w.req = '{req_type: t, range_start: s, range_end: e, point: p, length: l};
        w.has_status = hs;
        w.status = st;
        table_rows = {table_rows, w};
    endfunction

    initial begin
        request_t r;
        int total_items;
        errors = 0;
        n_resp = 0;
        n_found = 0;
        n_full = 0;
        iv_count = 0;
        span_seen = 0;
        largest_cache = 0;
        lowest_first = 1;
        stall_hold = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        add_row(fim_pkg::REQ_LARGEST, 0, 0, 0, 0, 1, fim_pkg::ST_NONE);
        add_row(fim_pkg::REQ_FIND_FIT, 0, 0, 0, 1, 1, fim_pkg::ST_NONE);
        add_row(fim_pkg::REQ_FIND_AT, 0, 0, 0, 0, 1, fim_pkg::ST_NONE);
        add_row(fim_pkg::REQ_RESERVE, 10, 20, 0, 0, 1, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RELEASE, 5, 5, 0, 0, 1, fim_pkg::ST_EMPTY);
        add_row(fim_pkg::REQ_RESERVE, 9, 3, 0, 0, 1, fim_pkg::ST_EMPTY);
        add_row(fim_pkg::REQ_RELEASE, 0, 31'h7fffffff, 0, 0, 1, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RESERVE, 100, 200, 0, 0, 1, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RESERVE, 0, 50, 0, 0, 1, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RELEASE, 200, 300, 0, 0, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RELEASE, 150, 200, 0, 0, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_FIND_AT, 0, 0, 150, 10, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_FIND_AT, 0, 0, 60, 20, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_FIND_AT, 0, 0, 120, 5, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_FIND_AT, 0, 0, 31'h7fffffff, 0, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_FIND_FIT, 0, 0, 0, 31'h7fffffff, 1, fim_pkg::ST_NONE);
        add_row(fim_pkg::REQ_FIND_FIT, 0, 0, 0, 40, 0, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_LARGEST, 0, 0, 0, 0, 1, fim_pkg::ST_OK);
        add_row(3'd5, 1, 2, 3, 4, 1, fim_pkg::ST_NONE);
        add_row(3'd7, 31'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff, 1, fim_pkg::ST_NONE);
        add_row(fim_pkg::REQ_RESERVE, 0, 31'h7fffffff, 0, 0, 1, fim_pkg::ST_OK);
        add_row(fim_pkg::REQ_RESERVE, 5, 6, 0, 0, 1, fim_pkg::ST_OK);
        foreach (table_rows[k])
            send_request(table_rows[k].req, table_rows[k].has_status, table_rows[k].status);

        // fill the table with unit holes to reach the full condition
        stall_hold = 1;
        for (int k = 0; k < 66; k++) begin
            r = '{req_type: fim_pkg::REQ_RELEASE, range_start: 31'(3*k),
                  range_end: 31'(3*k + 1), point: 0, length: 0};
            send_request(r, 1'b0, fim_pkg::ST_OK);
        end
        r = '{req_type: fim_pkg::REQ_RESERVE, range_start: 60, range_end: 61, point: 0,
              length: 0};
        send_request(r, 1'b0, fim_pkg::ST_OK);
        r = '{req_type: fim_pkg::REQ_RELEASE, range_start: 0, range_end: 400, point: 0,
              length: 0};
        send_request(r, 1'b0, fim_pkg::ST_OK);
        stall_hold = 0;

        total_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_policy(ph[0]);
            for (int k = 0; k < 500; k++) begin
                send_request(rnd_request(ph >= 2), 1'b0, fim_pkg::ST_OK);
                total_items++;
            end
            if (ph == 1) begin
                r = '{req_type: fim_pkg::REQ_RESERVE, range_start: 0,
                      range_end: 31'h7fffffff, point: 0, length: 0};
                send_request(r, 1'b0, fim_pkg::ST_OK);
            end
        end
        write_policy(1);

        while (pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d random and %0d directed requests, %0d responses",
                 total_items, table_rows.size(), n_resp);
        $display("found/done %0d, table full %0d", n_found, n_full);
        if (errors == 0) begin
            $display("tb_free_interval_manager OK");
        end else begin
            $display("tb_free_interval_manager NOT OK");
        end
        $finish;
    end
endmodule
